// ===== src/ps2mq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mq_pkg: shared types and constants of the ps/2 mouse event queue
// event and command formats, queue sizes and pointer helper
// ----------------------------------------------------------------------------
package ps2mq_pkg;

  // event queue: QUEUE_DEPTH slots, QUEUE_DEPTH-1 usable
  localparam int QUEUE_DEPTH = 32;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // command queue between front and back
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  localparam int BYTE_W      = 8;
  localparam int BUTTON_W    = 3;
  localparam int DY_W        = BYTE_W + 1;
  localparam int EVT_W       = BUTTON_W + 2 * BYTE_W;

  // status register flag for auxiliary device data
  localparam int AUX_BIT     = 5;

  // item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // byte count of the last byte of a packet
  localparam logic [1:0] PKT_LAST = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP
  } op_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] buttons;
    logic [BYTE_W-1:0]   raw_dx;
    logic [BYTE_W-1:0]   raw_dy;
  } evt_t;

  typedef struct packed {
    op_t  op;
    evt_t evt;
  } cmd_t;

  function automatic logic [QPTR_W-1:0] next_qptr(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== src/ps2mq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mq_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle; read data holds without re
// ----------------------------------------------------------------------------
module ps2mq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ps2mq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mq_front: input beat classification and packet assembly
// turns every accepted beat into one command for the back end
// ----------------------------------------------------------------------------
module ps2mq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [ps2mq_pkg::BYTE_W-1:0]  in_status_byte,
  input  logic [ps2mq_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                          cmdq_full,
  output logic                          cmd_push,
  output ps2mq_pkg::cmd_t               cmd
);

  logic [1:0]                     byte_count_r, byte_count_nxt;
  logic [ps2mq_pkg::BYTE_W-1:0]   pkt0_r, pkt0_nxt;
  logic [ps2mq_pkg::BYTE_W-1:0]   pkt1_r, pkt1_nxt;
  logic                           accept;

  assign in_stall = cmdq_full;
  assign accept   = in_valid && !cmdq_full;
  assign cmd_push = accept;

  always_comb begin
    byte_count_nxt     = byte_count_r;
    pkt0_nxt           = pkt0_r;
    pkt1_nxt           = pkt1_r;
    cmd.op             = ps2mq_pkg::OP_NOP;
    cmd.evt.buttons    = pkt0_r[ps2mq_pkg::BUTTON_W-1:0];
    cmd.evt.raw_dx     = pkt1_r;
    cmd.evt.raw_dy     = in_data_byte;
    if (accept) begin
      case (in_kind)
        ps2mq_pkg::KIND_POP: begin
          cmd.op = ps2mq_pkg::OP_POP;
        end
        ps2mq_pkg::KIND_BYTE: begin
          if (in_status_byte[ps2mq_pkg::AUX_BIT]) begin
            if (byte_count_r == ps2mq_pkg::PKT_LAST) begin
              byte_count_nxt = '0;
              cmd.op         = ps2mq_pkg::OP_PUSH;
            end else begin
              if (byte_count_r == 2'd0) begin
                pkt0_nxt = in_data_byte;
              end else begin
                pkt1_nxt = in_data_byte;
              end
              byte_count_nxt = byte_count_r + 2'd1;
            end
          end
        end
        default: begin
          cmd.op = ps2mq_pkg::OP_NOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

  // packet bytes are always written before use
  always_ff @(posedge clk) begin
    pkt0_r <= pkt0_nxt;
    pkt1_r <= pkt1_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r != 2'd3)
    else $error("byte count out of range");

endmodule

// ===== src/ps2mq_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mq_cmd_fifo: short command queue between front and back
// decouples input acceptance from result back-pressure
// ----------------------------------------------------------------------------
module ps2mq_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ps2mq_pkg::cmd_t push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output ps2mq_pkg::cmd_t head_cmd
);

  ps2mq_pkg::cmd_t                     slot_r [ps2mq_pkg::CMDQ_DEPTH];
  logic [ps2mq_pkg::CMDQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ps2mq_pkg::CMDQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ps2mq_pkg::CMDQ_CNT_W-1:0]    count_r, count_nxt;

  function automatic logic [ps2mq_pkg::CMDQ_PTR_W-1:0] bump(
    input logic [ps2mq_pkg::CMDQ_PTR_W-1:0] p);
    logic [ps2mq_pkg::CMDQ_PTR_W-1:0] r;
    if (p == ps2mq_pkg::CMDQ_PTR_W'(ps2mq_pkg::CMDQ_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ps2mq_pkg::CMDQ_PTR_W'(1);
    end
    return r;
  endfunction

  assign full       = (count_r == ps2mq_pkg::CMDQ_CNT_W'(ps2mq_pkg::CMDQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + ps2mq_pkg::CMDQ_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - ps2mq_pkg::CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command queue underrun");

endmodule

// ===== src/ps2mq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mq_back: event queue execution and result register
// carries out push, pop and no-op commands against the event ram
// ----------------------------------------------------------------------------
module ps2mq_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_valid,
  input  ps2mq_pkg::cmd_t                     cmd,
  output logic                                cmd_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_event_valid,
  output logic signed [ps2mq_pkg::BYTE_W-1:0] out_delta_x,
  output logic signed [ps2mq_pkg::DY_W-1:0]   out_delta_y,
  output logic [ps2mq_pkg::BUTTON_W-1:0]      out_button_bits,
  output logic                                out_queue_nonempty
);

  logic [ps2mq_pkg::QPTR_W-1:0] wp_r, wp_nxt;
  logic [ps2mq_pkg::QPTR_W-1:0] rp_r, rp_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         ev_r, ev_nxt;
  logic                         nonempty_r;
  logic                         issue;
  logic                         q_full, q_empty;
  logic                         ram_we, ram_re;
  logic [ps2mq_pkg::EVT_W-1:0]  ram_rdata;
  ps2mq_pkg::evt_t              rd_evt;

  assign issue   = cmd_valid && (!out_valid_r || !out_stall);
  assign cmd_pop = issue;
  assign q_empty = (wp_r == rp_r);
  assign q_full  = (ps2mq_pkg::next_qptr(wp_r) == rp_r);

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ev_nxt = 1'b0;
    if (issue) begin
      case (cmd.op)
        ps2mq_pkg::OP_PUSH: begin
          if (!q_full) begin
            ram_we = 1'b1;
            wp_nxt = ps2mq_pkg::next_qptr(wp_r);
          end
        end
        ps2mq_pkg::OP_POP: begin
          if (!q_empty) begin
            ram_re = 1'b1;
            ev_nxt = 1'b1;
            rp_nxt = ps2mq_pkg::next_qptr(rp_r);
          end
        end
        default: begin
          ev_nxt = 1'b0;
        end
      endcase
    end
    if (issue) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  ps2mq_ram #(
    .WIDTH (ps2mq_pkg::EVT_W),
    .DEPTH (ps2mq_pkg::QUEUE_DEPTH)
  ) u_evt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (cmd.evt),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ev_r       <= ev_nxt;
      nonempty_r <= (wp_nxt != rp_nxt);
    end
  end

  assign rd_evt             = ps2mq_pkg::evt_t'(ram_rdata);
  assign out_valid          = out_valid_r;
  assign out_event_valid    = ev_r;
  assign out_delta_x        = ev_r ? rd_evt.raw_dx : '0;
  assign out_delta_y        = ev_r ? ps2mq_pkg::DY_W'(ps2mq_pkg::DY_W'(0) -
                              {rd_evt.raw_dy[ps2mq_pkg::BYTE_W-1], rd_evt.raw_dy}) : '0;
  assign out_button_bits    = ev_r ? rd_evt.buttons : '0;
  assign out_queue_nonempty = nonempty_r;

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && cmd.op == ps2mq_pkg::OP_POP && q_empty) |=> !ev_r)
    else $error("event returned from empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && cmd.op == ps2mq_pkg::OP_PUSH && !q_full) |=> (nonempty_r && wp_r != rp_r))
    else $error("push did not leave queue non-empty");

  a_idle_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    !issue |=> ($stable(wp_r) && $stable(rp_r)))
    else $error("queue pointers moved without a command");

endmodule

// ===== src/ps2_mouse_packet_event_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_event_queue: ps/2 mouse packet decoder with event queue
// assembles three-byte mouse packets and queues decoded movement events
// ----------------------------------------------------------------------------
// Takes one input beat per clock and returns exactly one result beat for each
// input beat, in order. A beat is a controller byte arrival (kind 0) or a pop
// request (kind 1). Byte arrivals count only with status bit 5 set; every
// third counted byte completes a packet and pushes an event, dropped silently
// when the queue already holds QUEUE_DEPTH-1 events. A pop returns the oldest
// event with dy negated to screen direction; results without an event carry
// zero fields. From input acceptance to out_valid a command passes the
// command queue slot, then the result register with the registered event ram read.
// Sustained rate is one beat per cycle; in_stall rises only when two
// commands wait in the command queue, i.e. when out_stall has held results.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_event_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [ps2mq_pkg::BYTE_W-1:0]        in_status_byte,
  input  logic [ps2mq_pkg::BYTE_W-1:0]        in_data_byte,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_event_valid,
  output logic signed [ps2mq_pkg::BYTE_W-1:0] out_delta_x,
  output logic signed [ps2mq_pkg::DY_W-1:0]   out_delta_y,
  output logic [ps2mq_pkg::BUTTON_W-1:0]      out_button_bits,
  output logic                                out_queue_nonempty
);

  // front to command queue
  logic            cmd_push;
  ps2mq_pkg::cmd_t front_cmd;
  logic            cmdq_full;

  // command queue to back
  logic            head_valid;
  ps2mq_pkg::cmd_t head_cmd;
  logic            cmd_pop;

  // front: classify beats, collect packet bytes, emit one command per beat
  ps2mq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_status_byte (in_status_byte),
    .in_data_byte   (in_data_byte),
    .cmdq_full      (cmdq_full),
    .cmd_push       (cmd_push),
    .cmd            (front_cmd)
  );

  // short queue so input and output stall independently
  ps2mq_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (front_cmd),
    .pop        (cmd_pop),
    .full       (cmdq_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: event ram, pointers and the result register
  ps2mq_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (head_valid),
    .cmd                (head_cmd),
    .cmd_pop            (cmd_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_valid    (out_event_valid),
    .out_delta_x        (out_delta_x),
    .out_delta_y        (out_delta_y),
    .out_button_bits    (out_button_bits),
    .out_queue_nonempty (out_queue_nonempty)
  );

endmodule
